>>> src/tpds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Touch packet decode and scale: shared package
// Widths, register reset values, register indexes and the structures that
// join the controller, the datapath and the register bank.
// ----------------------------------------------------------------------------
package tpds_pkg;

   // Field and datapath widths.
   localparam int ByteW   = 8;
   localparam int RawW    = 10;                    // raw X or Y reading
   localparam int ResW    = 13;                    // screen resolution
   localparam int DiffW   = RawW + 1;              // signed raw - low, high - low
   localparam int ProdW   = DiffW + ResW + 1;      // signed (raw - low) * res
   localparam int MagW    = 23;                    // |product| is below 2**23
   localparam int RemW    = RawW + 1;              // partial remainder
   localparam int ValW    = 26;                    // quotient after inversion
   localparam int CoordW  = 16;                    // saturated coordinate
   localparam int CntW    = $clog2(MagW);          // divide step counter
   localparam int AddrW   = 5;                     // byte address of 8 words
   localparam int DataW   = 32;

   // Register reset values.
   localparam logic [RawW-1:0] XLowRst       = RawW'(73);
   localparam logic [RawW-1:0] XHighRst      = RawW'(956);
   localparam logic [RawW-1:0] YLowRst       = RawW'(883);
   localparam logic [RawW-1:0] YHighRst      = RawW'(167);
   localparam logic [ResW-1:0] ScreenWidthRst  = ResW'(640);
   localparam logic [ResW-1:0] ScreenHeightRst = ResW'(480);

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_X_LOW         = 3'd0,
      REG_X_HIGH        = 3'd1,
      REG_Y_LOW         = 3'd2,
      REG_Y_HIGH        = 3'd3,
      REG_INVERT_X      = 3'd4,
      REG_INVERT_Y      = 3'd5,
      REG_SCREEN_WIDTH  = 3'd6,
      REG_SCREEN_HEIGHT = 3'd7
   } reg_index_type;

   // Calibration settings as seen by the datapath.
   typedef struct packed {
      logic [RawW-1:0] x_low;
      logic [RawW-1:0] x_high;
      logic [RawW-1:0] y_low;
      logic [RawW-1:0] y_high;
      logic            invert_x;
      logic            invert_y;
      logic [ResW-1:0] screen_width;
      logic [ResW-1:0] screen_height;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_header;   // start byte: keep its low seven bits
      logic load_xbits;    // first data byte
      logic load_ybits;    // second data byte
      logic axis_sel;      // 0 works on X, 1 on Y
      logic mul;           // register offset times resolution and the span
      logic load_div;      // take magnitudes into the divider
      logic div_step;      // one restoring divide step
      logic finish;        // sign, zero span, inversion and saturation
      logic load_out;      // copy both coordinates to the result register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;      // the current divide step is the last one
   } dp_sts_type;

endpackage
`default_nettype wire

>>> src/tpds_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Touch packet decode and scale: calibration register bank
// Eight word registers on an APB-style port, always ready, read back
// zero-extended from the bits that each register keeps.
// ----------------------------------------------------------------------------
module tpds_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [tpds_pkg::AddrW-1:0]   paddr,
   input  wire logic [tpds_pkg::DataW-1:0]   pwdata,
   output logic      [tpds_pkg::DataW-1:0]   prdata,
   output logic                              pready,
   output tpds_pkg::cfg_type                 cfg_o
);

   tpds_pkg::cfg_type       cfg_ff;
   tpds_pkg::reg_index_type index;
   logic                    write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;
   assign index    = tpds_pkg::reg_index_type'(paddr[tpds_pkg::AddrW-1:2]);
   assign cfg_o    = cfg_ff;

   // Register writes; each register keeps only its own width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_low         <= tpds_pkg::XLowRst;
         cfg_ff.x_high        <= tpds_pkg::XHighRst;
         cfg_ff.y_low         <= tpds_pkg::YLowRst;
         cfg_ff.y_high        <= tpds_pkg::YHighRst;
         cfg_ff.invert_x      <= 1'b0;
         cfg_ff.invert_y      <= 1'b0;
         cfg_ff.screen_width  <= tpds_pkg::ScreenWidthRst;
         cfg_ff.screen_height <= tpds_pkg::ScreenHeightRst;
      end else if (write_en) begin
         case (index)
            tpds_pkg::REG_X_LOW:         cfg_ff.x_low  <= pwdata[tpds_pkg::RawW-1:0];
            tpds_pkg::REG_X_HIGH:        cfg_ff.x_high <= pwdata[tpds_pkg::RawW-1:0];
            tpds_pkg::REG_Y_LOW:         cfg_ff.y_low  <= pwdata[tpds_pkg::RawW-1:0];
            tpds_pkg::REG_Y_HIGH:        cfg_ff.y_high <= pwdata[tpds_pkg::RawW-1:0];
            tpds_pkg::REG_INVERT_X:      cfg_ff.invert_x <= pwdata[0];
            tpds_pkg::REG_INVERT_Y:      cfg_ff.invert_y <= pwdata[0];
            tpds_pkg::REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= pwdata[tpds_pkg::ResW-1:0];
            tpds_pkg::REG_SCREEN_HEIGHT: cfg_ff.screen_height <= pwdata[tpds_pkg::ResW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      case (index)
         tpds_pkg::REG_X_LOW:         prdata = tpds_pkg::DataW'(cfg_ff.x_low);
         tpds_pkg::REG_X_HIGH:        prdata = tpds_pkg::DataW'(cfg_ff.x_high);
         tpds_pkg::REG_Y_LOW:         prdata = tpds_pkg::DataW'(cfg_ff.y_low);
         tpds_pkg::REG_Y_HIGH:        prdata = tpds_pkg::DataW'(cfg_ff.y_high);
         tpds_pkg::REG_INVERT_X:      prdata = tpds_pkg::DataW'(cfg_ff.invert_x);
         tpds_pkg::REG_INVERT_Y:      prdata = tpds_pkg::DataW'(cfg_ff.invert_y);
         tpds_pkg::REG_SCREEN_WIDTH:  prdata = tpds_pkg::DataW'(cfg_ff.screen_width);
         tpds_pkg::REG_SCREEN_HEIGHT: prdata = tpds_pkg::DataW'(cfg_ff.screen_height);
         default:                     prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> src/tpds_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Touch packet decode and scale: datapath
// Packet byte registers, one multiplier, a shared restoring divider used
// for X and then Y, the sign, inversion and saturation stage, and the result
// register.
// ----------------------------------------------------------------------------
module tpds_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tpds_pkg::ByteW-1:0]     req_rx_byte,
   input  tpds_pkg::cfg_type                   cfg_i,
   input  tpds_pkg::dp_cmd_type                cmd_i,
   output tpds_pkg::dp_sts_type                sts_o,
   output logic signed [tpds_pkg::CoordW-1:0]  rsp_x_pos,
   output logic signed [tpds_pkg::CoordW-1:0]  rsp_y_pos,
   output logic                                rsp_pen_down
);

   localparam int RawW   = tpds_pkg::RawW;
   localparam int ResW   = tpds_pkg::ResW;
   localparam int DiffW  = tpds_pkg::DiffW;
   localparam int ProdW  = tpds_pkg::ProdW;
   localparam int MagW   = tpds_pkg::MagW;
   localparam int RemW   = tpds_pkg::RemW;
   localparam int ValW   = tpds_pkg::ValW;
   localparam int CoordW = tpds_pkg::CoordW;
   localparam int CntW   = tpds_pkg::CntW;

   // Packet bytes.
   logic [6:0] header_ff;
   logic [6:0] xbits_ff;
   logic [6:0] ybits_ff;

   // Multiply and divide registers.
   logic signed [ProdW-1:0] prod_ff;
   logic signed [DiffW-1:0] span_ff;
   logic [MagW-1:0]         quo_ff;
   logic [RemW-1:0]         rem_ff;
   logic [RawW-1:0]         div_ff;
   logic                    neg_ff;
   logic [CntW-1:0]         cnt_ff;

   // Per-axis results waiting for the result register.
   logic signed [CoordW-1:0] x_res_ff;
   logic signed [CoordW-1:0] y_res_ff;

   // Axis operand selection.
   logic [RawW-1:0]         raw;
   logic [RawW-1:0]         lo;
   logic [RawW-1:0]         hi;
   logic [ResW-1:0]         res;
   logic                    inv;
   logic signed [DiffW-1:0] diff;
   logic signed [DiffW-1:0] span;
   logic signed [ResW:0]    res_s;
   logic signed [ProdW-1:0] prod;

   always_comb begin
      if (cmd_i.axis_sel) begin
         raw = {header_ff[2:0], ybits_ff};
         lo  = cfg_i.y_low;
         hi  = cfg_i.y_high;
         res = cfg_i.screen_height;
         inv = cfg_i.invert_y;
      end else begin
         raw = {header_ff[5:3], xbits_ff};
         lo  = cfg_i.x_low;
         hi  = cfg_i.x_high;
         res = cfg_i.screen_width;
         inv = cfg_i.invert_x;
      end
      diff  = $signed({1'b0, raw}) - $signed({1'b0, lo});
      span  = $signed({1'b0, hi}) - $signed({1'b0, lo});
      res_s = $signed({1'b0, res});
      prod  = diff * res_s;
   end

   // Magnitudes for the unsigned divider.
   logic [ProdW-1:0] prod_abs;
   logic [DiffW-1:0] span_abs;

   assign prod_abs = prod_ff[ProdW-1] ? ProdW'(-prod_ff) : ProdW'(prod_ff);
   assign span_abs = span_ff[DiffW-1] ? DiffW'(-span_ff) : DiffW'(span_ff);

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   logic [RemW-1:0] rem_shift;
   logic            fits;

   assign rem_shift = {rem_ff[RemW-2:0], quo_ff[MagW-1]};
   assign fits      = rem_shift >= {1'b0, div_ff};

   assign sts_o.div_last = cnt_ff == CntW'(MagW - 1);

   // Signed quotient, zero span, inversion and saturation.
   logic signed [ValW-1:0]   quo_ext;
   logic signed [ValW-1:0]   quo_s;
   logic signed [ValW-1:0]   val;
   logic                     ovf_pos;
   logic                     ovf_neg;
   logic signed [CoordW-1:0] coord;

   always_comb begin
      quo_ext = $signed({{(ValW - MagW){1'b0}}, quo_ff});
      if (span_ff == '0) begin
         quo_s = '0;
      end else if (neg_ff) begin
         quo_s = -quo_ext;
      end else begin
         quo_s = quo_ext;
      end
      if (inv) begin
         val = $signed({{(ValW - ResW){1'b0}}, res}) - quo_s;
      end else begin
         val = quo_s;
      end
      ovf_pos = !val[ValW-1] && (val[ValW-2:CoordW-1] != '0);
      ovf_neg = val[ValW-1] && !(&val[ValW-2:CoordW-1]);
      if (ovf_pos) begin
         coord = {1'b0, {(CoordW - 1){1'b1}}};
      end else if (ovf_neg) begin
         coord = {1'b1, {(CoordW - 1){1'b0}}};
      end else begin
         coord = val[CoordW-1:0];
      end
   end

   // Packet byte capture.
   always_ff @(posedge clock) begin
      if (cmd_i.load_header) begin
         header_ff <= req_rx_byte[6:0];
      end
      if (cmd_i.load_xbits) begin
         xbits_ff <= req_rx_byte[6:0];
      end
      if (cmd_i.load_ybits) begin
         ybits_ff <= req_rx_byte[6:0];
      end
   end

   // Multiply, divide and result registers.
   always_ff @(posedge clock) begin
      if (cmd_i.mul) begin
         prod_ff <= prod;
         span_ff <= span;
      end
      if (cmd_i.load_div) begin
         quo_ff <= prod_abs[MagW-1:0];
         div_ff <= span_abs[RawW-1:0];
         rem_ff <= '0;
         neg_ff <= prod_ff[ProdW-1] ^ span_ff[DiffW-1];
      end else if (cmd_i.div_step) begin
         rem_ff <= fits ? RemW'(rem_shift - {1'b0, div_ff}) : rem_shift;
         quo_ff <= {quo_ff[MagW-2:0], fits};
      end
      if (cmd_i.finish) begin
         if (cmd_i.axis_sel) begin
            y_res_ff <= coord;
         end else begin
            x_res_ff <= coord;
         end
      end
      if (cmd_i.load_out) begin
         rsp_x_pos    <= x_res_ff;
         rsp_y_pos    <= y_res_ff;
         rsp_pen_down <= header_ff[6];
      end
   end

   // Divide step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd_i.load_div) begin
         cnt_ff <= '0;
      end else if (cmd_i.div_step) begin
         cnt_ff <= cnt_ff + CntW'(1);
      end
   end

   // The partial remainder always stays below a non-zero divisor.
   assert property (@(posedge clock) disable iff (reset)
      cmd_i.div_step && div_ff != '0 |-> rem_ff < {1'b0, div_ff})
      else $error("divider remainder not below divisor");

   // The step counter never runs past the quotient width.
   assert property (@(posedge clock) disable iff (reset)
      cmd_i.div_step |-> cnt_ff <= CntW'(MagW - 1))
      else $error("divide step counter overran");

endmodule
`default_nettype wire

>>> src/tpds_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Touch packet decode and scale: controller
// Frames start and data bytes into packets and sequences the multiply,
// divide and finish steps for X and then Y, then the result hand-over.
// ----------------------------------------------------------------------------
module tpds_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            is_start,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  tpds_pkg::dp_sts_type sts_i,
   output tpds_pkg::dp_cmd_type cmd_o
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_START,
      PH_FIRST,
      PH_SECOND
   } phase_type;

   state_type state_ff;
   phase_type phase_ff;
   logic      axis_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Datapath commands decoded from the state.
   always_comb begin
      cmd_o          = '0;
      cmd_o.axis_sel = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_o.load_header = is_start;
               cmd_o.load_xbits  = !is_start && phase_ff == PH_FIRST;
               cmd_o.load_ybits  = !is_start && phase_ff == PH_SECOND;
            end
         end
         ST_MUL:  cmd_o.mul      = 1'b1;
         ST_LOAD: cmd_o.load_div = 1'b1;
         ST_DIV:  cmd_o.div_step = 1'b1;
         ST_FIN:  cmd_o.finish   = 1'b1;
         ST_OUT:  cmd_o.load_out = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   // State, framing phase, axis and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_START;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_o.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (is_start) begin
                     // A start byte always opens a new packet.
                     phase_ff <= PH_FIRST;
                  end else if (phase_ff == PH_FIRST) begin
                     phase_ff <= PH_SECOND;
                  end else if (phase_ff == PH_SECOND) begin
                     phase_ff <= PH_START;
                     axis_ff  <= 1'b0;
                     state_ff <= ST_MUL;
                  end else begin
                     phase_ff <= PH_START;
                  end
               end
            end
            ST_MUL:  state_ff <= ST_LOAD;
            ST_LOAD: state_ff <= ST_DIV;
            ST_DIV: begin
               if (sts_i.div_last) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!axis_ff) begin
                  axis_ff  <= 1'b1;
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (cmd_o.load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The closing data byte of a packet starts the X computation.
   assert property (@(posedge clock) disable iff (reset)
      accept && !is_start && phase_ff == PH_SECOND |=> state_ff == ST_MUL && !axis_ff)
      else $error("packet completion did not start the X computation");

   // A finished result does not overwrite one still waiting to be taken.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && rsp_stall |=> state_ff == ST_OUT)
      else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

>>> src/touch_packet_decode_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Touch packet decode and scale
// Frames three-byte touchscreen packets, scales raw X and Y with the
// calibration registers and delivers saturated screen coordinates.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  req      in         req_valid / req_stall     req_rx_byte
//  rsp      out        rsp_valid / rsp_stall     rsp_x_pos, rsp_y_pos, rsp_pen_down
//  csr      in         psel / penable / pready   paddr, pwdata, prdata
//
//  A start byte or first data byte is taken without a stall. The closing data
//  byte holds the input stalled while, per axis, the multiply, the divider
//  load, 23 restoring divide steps and the finish step run on the single
//  shared divider, and then until the result register is loaded.
//  Reset is synchronous and restores the calibration defaults.
//  A result stalled at the output holds the next packet in the result stage.
// ----------------------------------------------------------------------------
module touch_packet_decode_scale (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [tpds_pkg::ByteW-1:0]         req_rx_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [tpds_pkg::CoordW-1:0]      rsp_x_pos,
   output logic signed [tpds_pkg::CoordW-1:0]      rsp_y_pos,
   output logic                                    rsp_pen_down,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [tpds_pkg::AddrW-1:0]         paddr,
   input  wire logic [tpds_pkg::DataW-1:0]         pwdata,
   output logic      [tpds_pkg::DataW-1:0]         prdata,
   output logic                                    pready
);

   tpds_pkg::cfg_type    cfg;
   tpds_pkg::dp_cmd_type cmd;
   tpds_pkg::dp_sts_type sts;

   // Calibration registers.
   tpds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg_o   (cfg)
   );

   // Framing and sequencing.
   tpds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .is_start  (req_rx_byte[tpds_pkg::ByteW-1]),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   // Arithmetic and result register.
   tpds_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_rx_byte  (req_rx_byte),
      .cfg_i        (cfg),
      .cmd_i        (cmd),
      .sts_o        (sts),
      .rsp_x_pos    (rsp_x_pos),
      .rsp_y_pos    (rsp_y_pos),
      .rsp_pen_down (rsp_pen_down)
   );

endmodule
`default_nettype wire

>>> test/touch_packet_decode_scale_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch packet decode and scale: testbench
// Streams touchscreen bytes into the decoder under several calibration
// settings. It predicts each coordinate result from its own copy of the
// framing state and the calibration registers, and compares every result
// field by field. The sender idles in bursts and the receiver stalls in
// varying patterns.
// ----------------------------------------------------------------------------
module touch_packet_decode_scale_tb;
   import tpds_pkg::*;

   // The slowest correct run is about 1500 requests, each with the longest gap,
   // block and stall, plus the phase changes. The limit is several times that.
   localparam int CycleLimit  = 1_000_000;
   localparam int SettleCycles = 80;
   localparam logic [ByteW-1:0] StartFlag = 8'h80;

   typedef enum logic [1:0] {
      AWAIT_START = 2'd0,
      AWAIT_X     = 2'd1,
      AWAIT_Y     = 2'd2
   } frame_phase_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_LONG
   } stall_mode_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x_pos;
      logic signed [CoordW-1:0] y_pos;
      logic                     pen_down;
   } coord_type;

   logic                     clock;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic [ByteW-1:0]         req_rx_byte  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic signed [CoordW-1:0] rsp_x_pos;
   logic signed [CoordW-1:0] rsp_y_pos;
   logic                     rsp_pen_down;
   logic                     psel         = 1'b0;
   logic                     penable      = 1'b0;
   logic                     pwrite       = 1'b0;
   logic [AddrW-1:0]         paddr        = '0;
   logic [DataW-1:0]         pwdata       = '0;
   logic [DataW-1:0]         prdata;
   logic                     pready;

   logic [ByteW-1:0] rx_byte_queue [$];
   coord_type        coord_queue [$];
   int               error_count = 0;
   int               cycle_count = 0;

   // Calibration and framing state as the decoder should hold them.
   cfg_type          calib;
   frame_phase_type  frame_phase;
   logic [6:0]       header_bits;
   logic [6:0]       x_bits;

   touch_packet_decode_scale u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_x_pos    (rsp_x_pos),
      .rsp_y_pos    (rsp_y_pos),
      .rsp_pen_down (rsp_pen_down),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Scales one raw reading: signed division truncating toward zero, a zero
   // span giving zero, optional inversion and saturation to 16 bits.
   function automatic logic signed [CoordW-1:0] calibrate_axis(
         input logic [RawW-1:0] raw, input logic [RawW-1:0] lo,
         input logic [RawW-1:0] hi, input logic [ResW-1:0] res, input logic inv);
      longint raw_l, lo_l, hi_l, res_l, span, v;
      raw_l = raw;
      lo_l  = lo;
      hi_l  = hi;
      res_l = res;
      span  = hi_l - lo_l;
      v     = 0;
      if (span != 0)
         v = ((raw_l - lo_l) * res_l) / span;
      if (inv)
         v = res_l - v;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[CoordW-1:0];
   endfunction

   // Advances the framing state by one byte; a closing data byte yields a result.
   task automatic decode_rx_byte(input logic [ByteW-1:0] b);
      logic [RawW-1:0] raw_x;
      logic [RawW-1:0] raw_y;
      coord_type       c;
      if (b[7]) begin
         // A start byte always opens a new packet, even mid-packet.
         header_bits = b[6:0];
         frame_phase = AWAIT_X;
      end else if (frame_phase == AWAIT_X) begin
         x_bits      = b[6:0];
         frame_phase = AWAIT_Y;
      end else if (frame_phase == AWAIT_Y) begin
         raw_x      = {header_bits[5:3], x_bits};
         raw_y      = {header_bits[2:0], b[6:0]};
         c.x_pos    = calibrate_axis(raw_x, calib.x_low, calib.x_high,
                                     calib.screen_width, calib.invert_x);
         c.y_pos    = calibrate_axis(raw_y, calib.y_low, calib.y_high,
                                     calib.screen_height, calib.invert_y);
         c.pen_down = header_bits[6];
         coord_queue.push_back(c);
         frame_phase = AWAIT_START;
      end else begin
         // Stray data byte while awaiting a start byte.
         frame_phase = AWAIT_START;
      end
   endtask

   // Predict on every accepted request.
   always @(posedge clock) begin
      if (reset) begin
         frame_phase = AWAIT_START;
         header_bits = '0;
         x_bits      = '0;
      end else if (req_valid && !req_stall) begin
         decode_rx_byte(req_rx_byte);
      end
   end

   // Track the calibration registers from the writes seen on the bus.
   always @(posedge clock) begin
      if (reset) begin
         calib <= '{x_low: XLowRst, x_high: XHighRst, y_low: YLowRst, y_high: YHighRst,
                    invert_x: 1'b0, invert_y: 1'b0, screen_width: ScreenWidthRst,
                    screen_height: ScreenHeightRst};
      end else if (psel && penable && pwrite && pready) begin
         case (reg_index_type'(paddr[AddrW-1:2]))
            REG_X_LOW:         calib.x_low         <= pwdata[RawW-1:0];
            REG_X_HIGH:        calib.x_high        <= pwdata[RawW-1:0];
            REG_Y_LOW:         calib.y_low         <= pwdata[RawW-1:0];
            REG_Y_HIGH:        calib.y_high        <= pwdata[RawW-1:0];
            REG_INVERT_X:      calib.invert_x      <= pwdata[0];
            REG_INVERT_Y:      calib.invert_y      <= pwdata[0];
            REG_SCREEN_WIDTH:  calib.screen_width  <= pwdata[ResW-1:0];
            REG_SCREEN_HEIGHT: calib.screen_height <= pwdata[ResW-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [DataW-1:0] calib_word(input reg_index_type idx);
      case (idx)
         REG_X_LOW:         return DataW'(calib.x_low);
         REG_X_HIGH:        return DataW'(calib.x_high);
         REG_Y_LOW:         return DataW'(calib.y_low);
         REG_Y_HIGH:        return DataW'(calib.y_high);
         REG_INVERT_X:      return DataW'(calib.invert_x);
         REG_INVERT_Y:      return DataW'(calib.invert_y);
         REG_SCREEN_WIDTH:  return DataW'(calib.screen_width);
         default:           return DataW'(calib.screen_height);
      endcase
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 8;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0 || rx_byte_queue.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_byte_queue.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
      end
   end

   // Receiver stall pattern: free running, scattered stalls, or long stalls.
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 200;
   int             run_left   = 0;
   logic           run_stall  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left  = $urandom_range(128, 512);
            stall_mode = stall_mode_type'($urandom_range(0, 2));
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (run_left == 0) begin
                  run_stall = !run_stall;
                  run_left  = run_stall ? $urandom_range(1, 60) : $urandom_range(1, 20);
               end else begin
                  run_left--;
               end
               rsp_stall <= run_stall;
            end
         endcase
      end
   end

   // Result monitor: each accepted result against the oldest prediction.
   always @(posedge clock) begin
      coord_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coord_queue.size() == 0) begin
            report_mismatch("result with no request waiting for it");
         end else begin
            want = coord_queue.pop_front();
            if (rsp_x_pos !== want.x_pos)
               report_mismatch($sformatf("x_pos %0d, expected %0d", rsp_x_pos, want.x_pos));
            if (rsp_y_pos !== want.y_pos)
               report_mismatch($sformatf("y_pos %0d, expected %0d", rsp_y_pos, want.y_pos));
            if (rsp_pen_down !== want.pen_down)
               report_mismatch($sformatf("pen_down %b, expected %b",
                                         rsp_pen_down, want.pen_down));
         end
      end
   end

   // One bus transfer: a setup phase, then an access phase until pready.
   task automatic csr_access(input reg_index_type idx, input logic write_en,
                             input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes every calibration register, then reads each one back.
   task automatic program_calibration(input logic [DataW-1:0] xl, xh, yl, yh,
                                      input logic [DataW-1:0] ix, iy, sw, sh);
      logic [DataW-1:0] words [8];
      logic [DataW-1:0] word;
      reg_index_type    idx;
      words = '{xl, xh, yl, yh, ix, iy, sw, sh};
      for (int i = 0; i < 8; i++) begin
         idx = reg_index_type'(i);
         csr_access(idx, 1'b1, words[i], word);
      end
      for (int i = 0; i < 8; i++) begin
         idx = reg_index_type'(i);
         csr_access(idx, 1'b0, '0, word);
         if (word !== calib_word(idx))
            report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                      idx.name(), word, calib_word(idx)));
      end
   endtask

   task automatic queue_packet(input logic pen, input logic [RawW-1:0] raw_x,
                               input logic [RawW-1:0] raw_y);
      rx_byte_queue.push_back(StartFlag | {1'b0, pen, raw_x[9:7], raw_y[9:7]});
      rx_byte_queue.push_back({1'b0, raw_x[6:0]});
      rx_byte_queue.push_back({1'b0, raw_y[6:0]});
   endtask

   // Raw readings at both ends of the range, both pen states.
   task automatic queue_corner_packets();
      queue_packet(1'b0, '0, '0);
      queue_packet(1'b1, '1, '1);
      queue_packet(1'b1, '0, '1);
      queue_packet(1'b0, '1, '0);
   endtask

   // Mostly well-formed packets; the rest are cut-off packets and stray bytes.
   task automatic queue_random_traffic(input int count);
      int queued;
      int pick;
      queued = 0;
      while (queued < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            queue_packet(1'($urandom_range(0, 1)), RawW'($urandom_range(0, 1023)),
                         RawW'($urandom_range(0, 1023)));
            queued += 3;
         end else if (pick < 90) begin
            // Start byte, perhaps one data byte, then the next start byte cuts in.
            rx_byte_queue.push_back(StartFlag | ByteW'($urandom_range(0, 127)));
            queued++;
            if ($urandom_range(0, 1)) begin
               rx_byte_queue.push_back(ByteW'($urandom_range(0, 127)));
               queued++;
            end
         end else begin
            rx_byte_queue.push_back(ByteW'($urandom));
            queued++;
         end
      end
   endtask

   // The sender holds off until every request has gone in and every
   // predicted result has come out, then lets the block settle.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (rx_byte_queue.size() != 0 || req_valid || coord_queue.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Stimulus sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset calibration.
      rx_byte_queue.push_back(8'h00);          // data bytes before any start
      rx_byte_queue.push_back(8'h7F);
      queue_packet(1'b1, '1, '1);
      queue_packet(1'b0, '0, '0);
      queue_packet(1'b1, 10'd73, 10'd883);     // exactly at the low points
      rx_byte_queue.push_back(8'hC5);          // cut-off packet: the next start cuts in
      rx_byte_queue.push_back(8'h12);
      queue_packet(1'b1, 10'd500, 10'd300);
      rx_byte_queue.push_back(8'h90);          // start byte straight after a start
      queue_packet(1'b0, 10'd956, 10'd167);    // exactly at the high points
      rx_byte_queue.push_back(8'h55);          // stray byte after a packet
      wait_until_drained();

      // Full range, resolution 4096.
      program_calibration(32'd0, 32'd1023, 32'd0, 32'd1023, 32'd0, 32'd0,
                          32'd4096, 32'd4096);
      queue_corner_packets();
      queue_random_traffic(150);
      wait_until_drained();

      // Mirrored X, zero span on Y, both inverted, smallest and largest resolution.
      program_calibration(32'd1023, 32'd0, 32'd500, 32'd500, 32'd1, 32'd1,
                          32'd1, 32'd8191);
      queue_corner_packets();
      queue_random_traffic(150);
      wait_until_drained();

      // Upper bits of the written words are dropped: zero resolution here.
      program_calibration(32'hFFFF_FC00, 32'hFFFF_FFFF, 32'hAAAA_A155, 32'h5555_52AA,
                          32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_E000, 32'h0000_2000);
      queue_corner_packets();
      queue_random_traffic(150);
      wait_until_drained();

      // Random calibrations.
      repeat (5) begin
         case ($urandom_range(0, 2))
            0: program_calibration($urandom_range(0, 300), $urandom_range(700, 1023),
                                   $urandom_range(700, 1023), $urandom_range(0, 300),
                                   $urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(1, 4096), $urandom_range(1, 4096));
            1: program_calibration($urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                                   $urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(1, 4096), $urandom_range(1, 4096));
            default: program_calibration($urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom, $urandom);
         endcase
         queue_random_traffic(200);
         wait_until_drained();
      end

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
